@@ rtl/smoothstep_waypoint_interpolator_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the smoothstep waypoint interpolator.
// ---------------------------------------------------------------------------
`ifndef SMOOTHSTEP_WAYPOINT_INTERPOLATOR_TOP_MACROS_SVH
`define SMOOTHSTEP_WAYPOINT_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication
`define SWI_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define SWI_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/swi_pkg.sv @@
// ---------------------------------------------------------------------------
// swi_pkg
// Types and constants shared by the waypoint interpolator modules.
// ---------------------------------------------------------------------------
package swi_pkg;

   localparam int STEPS_W   = 7;
   localparam int TIME_W    = 16;
   localparam int POS_W     = 21;
   localparam int ATT_W     = 16;
   localparam int RATE_W    = 10;
   localparam int ALPHA_W   = 17;
   localparam int PROD_W    = TIME_W + RATE_W;
   localparam int DIV_ITERS = 17;
   localparam int MS_PER_S  = 1000;

   localparam logic CSR_RATE  = 1'b0;
   localparam logic CSR_TOTAL = 1'b1;

   typedef enum logic [2:0] {
      ST_POSE  = 3'd0,
      ST_START = 3'd1,
      ST_ORDER = 3'd2,
      ST_END   = 3'd3,
      ST_FAULT = 3'd4
   } status_type;

   typedef logic [2:0][POS_W-1:0] pos_vec_type;
   typedef logic [2:0][ATT_W-1:0] att_vec_type;

   typedef struct packed {
      status_type           status;
      logic [STEPS_W-1:0]   steps;
      logic [TIME_W-1:0]    prev_time;
      logic [TIME_W-1:0]    dur;
      pos_vec_type          prev_pos;
      pos_vec_type          new_pos;
      att_vec_type          prev_att;
      att_vec_type          new_att;
   } cmd_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIV,
      B_STEP
   } back_state_type;

endpackage

@@ rtl/swi_front.sv @@
// ---------------------------------------------------------------------------
// swi_front
// Accepts waypoints, checks ordering and faults, keeps the previous
// waypoint and works out the step count of each segment.
// ---------------------------------------------------------------------------
module swi_front
   import swi_pkg::*;
#(
   parameter int MAX_STEPS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_first,
   input  logic                 req_final,
   input  logic [TIME_W-1:0]    req_time,
   input  pos_vec_type          req_pos,
   input  att_vec_type          req_att,
   input  logic [RATE_W-1:0]    rate,
   input  logic [TIME_W-1:0]    total,
   output logic                 push_valid,
   input  logic                 push_ready,
   output cmd_type              push_cmd
);

   front_state_type       st_ff, st_in;
   logic                  have_prev_ff, have_prev_in;
   logic                  fault_ff, fault_in;
   logic [TIME_W-1:0]     prev_time_ff, prev_time_in;
   pos_vec_type           prev_pos_ff, prev_pos_in;
   att_vec_type           prev_att_ff, prev_att_in;
   cmd_type               cmd_ff, cmd_in;
   logic                  seg_ff, seg_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [STEPS_W-1:0]    steps_calc;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= F_IDLE;
         have_prev_ff <= 1'b0;
         fault_ff     <= 1'b0;
         prev_time_ff <= '0;
         prev_pos_ff  <= '0;
         prev_att_ff  <= '0;
      end else begin
         st_ff        <= st_in;
         have_prev_ff <= have_prev_in;
         fault_ff     <= fault_in;
         prev_time_ff <= prev_time_in;
         prev_pos_ff  <= prev_pos_in;
         prev_att_ff  <= prev_att_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      seg_ff  <= seg_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      logic [PROD_W:0]    x;
      logic [TIME_W-1:0]  r;
      logic [5:0]         q;
      x = {1'b0, prod_ff} + (PROD_W+1)'(MS_PER_S / 2);
      r = x[TIME_W-1:0];
      q = '0;
      for (int i = 5; i >= 0; i--) begin
         if (r >= TIME_W'(MS_PER_S << i)) begin
            r    = r - TIME_W'(MS_PER_S << i);
            q[i] = 1'b1;
         end
      end
      if (x >= (PROD_W+1)'(MAX_STEPS * MS_PER_S)) begin
         steps_calc = STEPS_W'(MAX_STEPS);
      end else if (q == '0) begin
         steps_calc = STEPS_W'(1);
      end else begin
         steps_calc = STEPS_W'(q);
      end
   end

   always_comb begin
      st_in        = st_ff;
      have_prev_in = have_prev_ff;
      fault_in     = fault_ff;
      prev_time_in = prev_time_ff;
      prev_pos_in  = prev_pos_ff;
      prev_att_in  = prev_att_ff;
      cmd_in       = cmd_ff;
      seg_in       = seg_ff;
      prod_in      = prod_ff;
      req_tready   = (st_ff == F_IDLE);
      push_valid   = 1'b0;
      push_cmd     = cmd_ff;
      case (st_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               st_in            = F_MUL;
               seg_in           = 1'b0;
               cmd_in           = '0;
               cmd_in.status    = ST_POSE;
               cmd_in.steps     = STEPS_W'(1);
               if (req_first) begin
                  fault_in     = 1'b0;
                  have_prev_in = 1'b0;
                  if (req_time != '0) begin
                     cmd_in.status = ST_START;
                     fault_in      = 1'b1;
                  end else if (req_final && req_time != total) begin
                     cmd_in.status = ST_END;
                     fault_in      = 1'b1;
                  end else begin
                     prev_time_in    = '0;
                     prev_pos_in     = req_pos;
                     prev_att_in     = req_att;
                     have_prev_in    = !req_final;
                     cmd_in.prev_pos = req_pos;
                     cmd_in.new_pos  = req_pos;
                     cmd_in.prev_att = req_att;
                     cmd_in.new_att  = req_att;
                  end
               end else if (fault_ff || !have_prev_ff) begin
                  cmd_in.status = ST_FAULT;
               end else if (req_time <= prev_time_ff) begin
                  cmd_in.status = ST_ORDER;
                  fault_in      = 1'b1;
               end else if (req_final && req_time != total) begin
                  cmd_in.status = ST_END;
                  fault_in      = 1'b1;
               end else begin
                  seg_in           = 1'b1;
                  cmd_in.prev_time = prev_time_ff;
                  cmd_in.dur       = req_time - prev_time_ff;
                  cmd_in.prev_pos  = prev_pos_ff;
                  cmd_in.new_pos   = req_pos;
                  cmd_in.prev_att  = prev_att_ff;
                  cmd_in.new_att   = req_att;
                  prev_time_in     = req_time;
                  prev_pos_in      = req_pos;
                  prev_att_in      = req_att;
                  if (req_final) begin
                     have_prev_in = 1'b0;
                  end
               end
            end
         end
         F_MUL: begin
            prod_in = cmd_ff.dur * rate;
            st_in   = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (seg_ff) begin
               push_cmd.steps = steps_calc;
            end
            if (push_ready) begin
               st_in = F_IDLE;
            end
         end
         default: begin
            st_in = F_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/swi_fifo.sv @@
// ---------------------------------------------------------------------------
// swi_fifo
// Two-entry request queue between the front and back sections.
// ---------------------------------------------------------------------------
module swi_fifo
   import swi_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  cmd_type  wr_cmd,
   output logic     rd_valid,
   input  logic     rd_ready,
   output cmd_type  rd_cmd
);

   cmd_type     mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_wr, do_rd;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_cmd   = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

@@ rtl/swi_back.sv @@
// ---------------------------------------------------------------------------
// swi_back
// Divides out the per-step increments, walks the steps of a segment and
// runs the smoothstep easing pipeline into the result register.
// ---------------------------------------------------------------------------
`include "smoothstep_waypoint_interpolator_top_macros.svh"

module swi_back
   import swi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_pop,
   input  cmd_type              cmd,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output status_type           rsp_status,
   output logic [TIME_W-1:0]    rsp_time,
   output pos_vec_type          rsp_pos,
   output att_vec_type          rsp_att,
   output logic                 rsp_last
);

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

   function automatic logic signed [23:0] round_q16(input logic signed [39:0] p);
      logic [39:0] mag;
      logic [39:0] q;
      mag = p[39] ? 40'(-p) : 40'(p);
      q   = (mag + 40'd32768) >> 16;
      return p[39] ? -24'(q) : 24'(q);
   endfunction

   back_state_type       st_ff, st_in;
   cmd_type              seg_ff;
   logic [ALPHA_W-1:0]   na_ff, nd_ff;
   logic [7:0]           ra_ff, rd_ff;
   logic [4:0]           cnt_ff;
   logic [STEPS_W-1:0]   k_ff;
   logic [ALPHA_W-1:0]   aacc_ff;
   logic [7:0]           racc_ff, rtacc_ff;
   logic [TIME_W-1:0]    tacc_ff;

   logic                 load, div_run, issue, adv, pipe_empty, last_issue;
   logic [7:0]           sx, s2x, sh_a, sh_d, ra_sum, rt_sum;
   logic                 ge_a, ge_d, gea, get;
   logic [ALPHA_W-1:0]   a_nxt;
   logic [TIME_W-1:0]    t_nxt;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic                 full1_ff, full2_ff;
   logic [15:0]          alo1_ff;
   logic [31:0]          sq1_ff;
   logic [49:0]          m2_ff;
   logic [ALPHA_W-1:0]   s3_ff;
   logic signed [39:0]   pp4_ff [3];
   logic signed [34:0]   pa4_ff [3];
   logic [TIME_W-1:0]    t1_ff, t2_ff, t3_ff, t4_ff;
   logic                 l1_ff, l2_ff, l3_ff, l4_ff;
   status_type           s1_ff, s2_ff, s3s_ff, s4_ff;
   status_type           rsp_status_ff;
   logic [TIME_W-1:0]    rsp_time_ff;
   pos_vec_type          rsp_pos_ff;
   att_vec_type          rsp_att_ff;
   logic                 rsp_last_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign pipe_empty = !(v1_ff || v2_ff || v3_ff || v4_ff);
   assign sx         = {1'b0, seg_ff.steps};
   assign s2x        = {seg_ff.steps, 1'b0};
   assign last_issue = (k_ff == seg_ff.steps);

   assign sh_a = {ra_ff[6:0], na_ff[ALPHA_W-1]};
   assign sh_d = {rd_ff[6:0], nd_ff[ALPHA_W-1]};
   assign ge_a = (sh_a >= sx);
   assign ge_d = (sh_d >= sx);

   assign ra_sum = racc_ff + ra_ff;
   assign gea    = (ra_sum >= sx);
   assign a_nxt  = aacc_ff + na_ff + ALPHA_W'(gea);
   assign rt_sum = rtacc_ff + {rd_ff[6:0], 1'b0};
   assign get    = (rt_sum >= s2x);
   assign t_nxt  = tacc_ff + nd_ff[TIME_W-1:0] + TIME_W'(get);

   always_comb begin
      st_in   = st_ff;
      cmd_pop = 1'b0;
      load    = 1'b0;
      div_run = 1'b0;
      issue   = 1'b0;
      case (st_ff)
         B_IDLE: begin
            if (cmd_valid && pipe_empty) begin
               cmd_pop = 1'b1;
               load    = 1'b1;
               st_in   = B_DIV;
            end
         end
         B_DIV: begin
            div_run = 1'b1;
            if (cnt_ff == 5'(DIV_ITERS - 1)) begin
               st_in = B_STEP;
            end
         end
         B_STEP: begin
            if (adv) begin
               issue = 1'b1;
               if (last_issue) begin
                  st_in = B_IDLE;
               end
            end
         end
         default: begin
            st_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (adv) begin
            v1_ff        <= issue;
            v2_ff        <= v1_ff;
            v3_ff        <= v2_ff;
            v4_ff        <= v3_ff;
            rsp_valid_ff <= v4_ff;
         end
      end
   end

   // divide and step walk
   always_ff @(posedge clock) begin
      if (load) begin
         seg_ff   <= cmd;
         na_ff    <= ALPHA_ONE;
         nd_ff    <= {1'b0, cmd.dur};
         ra_ff    <= '0;
         rd_ff    <= '0;
         cnt_ff   <= '0;
         k_ff     <= STEPS_W'(1);
         aacc_ff  <= '0;
         racc_ff  <= '0;
         tacc_ff  <= cmd.prev_time;
         rtacc_ff <= {1'b0, cmd.steps};
      end
      if (div_run) begin
         ra_ff  <= ge_a ? sh_a - sx : sh_a;
         rd_ff  <= ge_d ? sh_d - sx : sh_d;
         na_ff  <= {na_ff[ALPHA_W-2:0], ge_a};
         nd_ff  <= {nd_ff[ALPHA_W-2:0], ge_d};
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (issue) begin
         aacc_ff  <= a_nxt;
         racc_ff  <= gea ? ra_sum - sx : ra_sum;
         tacc_ff  <= t_nxt;
         rtacc_ff <= get ? rt_sum - s2x : rt_sum;
         k_ff     <= k_ff + STEPS_W'(1);
      end
   end

   // easing pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         full1_ff <= a_nxt[ALPHA_W-1];
         alo1_ff  <= a_nxt[15:0];
         sq1_ff   <= a_nxt[15:0] * a_nxt[15:0];
         t1_ff    <= t_nxt;
         l1_ff    <= last_issue;
         s1_ff    <= seg_ff.status;

         full2_ff <= full1_ff;
         m2_ff    <= sq1_ff * (18'd196608 - {1'b0, alo1_ff, 1'b0});
         t2_ff    <= t1_ff;
         l2_ff    <= l1_ff;
         s2_ff    <= s1_ff;

         s3_ff    <= full2_ff ? ALPHA_ONE : ALPHA_W'((m2_ff + 50'h80000000) >> 32);
         t3_ff    <= t2_ff;
         l3_ff    <= l2_ff;
         s3s_ff   <= s2_ff;

         for (int i = 0; i < 3; i++) begin
            pp4_ff[i] <= $signed({1'b0, s3_ff}) *
               ($signed({seg_ff.new_pos[i][POS_W-1], seg_ff.new_pos[i]}) -
                $signed({seg_ff.prev_pos[i][POS_W-1], seg_ff.prev_pos[i]}));
            pa4_ff[i] <= $signed({1'b0, s3_ff}) *
               ($signed({seg_ff.new_att[i][ATT_W-1], seg_ff.new_att[i]}) -
                $signed({seg_ff.prev_att[i][ATT_W-1], seg_ff.prev_att[i]}));
         end
         t4_ff <= t3_ff;
         l4_ff <= l3_ff;
         s4_ff <= s3s_ff;

         rsp_status_ff <= s4_ff;
         rsp_last_ff   <= l4_ff;
         rsp_time_ff   <= (s4_ff == ST_POSE) ? t4_ff : '0;
         for (int i = 0; i < 3; i++) begin
            rsp_pos_ff[i] <= (s4_ff == ST_POSE) ?
               POS_W'($signed({{3{seg_ff.prev_pos[i][POS_W-1]}}, seg_ff.prev_pos[i]}) +
                      round_q16(pp4_ff[i])) : '0;
            rsp_att_ff[i] <= (s4_ff == ST_POSE) ?
               ATT_W'($signed({{8{seg_ff.prev_att[i][ATT_W-1]}}, seg_ff.prev_att[i]}) +
                      round_q16({{5{pa4_ff[i][34]}}, pa4_ff[i]})) : '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_time   = rsp_time_ff;
   assign rsp_pos    = rsp_pos_ff;
   assign rsp_att    = rsp_att_ff;
   assign rsp_last   = rsp_last_ff;

   `SWI_ASSERT_NEXT(a_seg_end, st_ff == B_STEP && issue && last_issue, st_ff == B_IDLE, "segment did not end after last step")
   `SWI_ASSERT_NOW(a_step_range, st_ff == B_STEP, k_ff != '0 && k_ff <= seg_ff.steps, "step index out of range")
   `SWI_ASSERT_NOW(a_alpha_end, issue && last_issue, a_nxt == ALPHA_ONE, "alpha not one at last step")

endmodule

@@ rtl/smoothstep_waypoint_interpolator_top.sv @@
// ---------------------------------------------------------------------------
// smoothstep_waypoint_interpolator_top
// Timed waypoints in, smoothstep-eased poses out.
// ---------------------------------------------------------------------------
// Path: front section (F_IDLE, F_MUL, F_PUSH), request queue, step divider
// and the 5-stage easing pipeline, from request accept to result accept.
// Throughput: one pose per cycle within a segment unless rsp_tready stalls
// the output; the back section takes no new request until its pipeline drains.
// Reset: synchronous; clears control and trajectory state and sets the rate
// and total-duration registers to 20 and 60000.
module smoothstep_waypoint_interpolator_top
   import swi_pkg::*;
#(
   parameter int MAX_STEPS = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // time_ms, pos_x, pos_y, pos_z, roll_cdeg, pitch_cdeg, yaw_cdeg, pad
   input  logic [127:0]   req_tdata,
   input  logic           req_tlast,
   // first
   input  logic           req_tuser,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // step_time_ms, out_x, out_y, out_z, out_roll, out_pitch, out_yaw, pad
   output logic [127:0]   rsp_tdata,
   output logic           rsp_tlast,
   // status
   output logic [2:0]     rsp_tuser,
   input  logic           csr_we,
   input  logic           csr_index,
   input  logic [15:0]    csr_wdata
);

   logic [RATE_W-1:0]  rate_ff;
   logic [TIME_W-1:0]  total_ff;
   pos_vec_type        req_pos, rsp_pos;
   att_vec_type        req_att, rsp_att;
   logic               push_valid, push_ready, q_valid, q_pop;
   cmd_type            push_cmd, q_cmd;
   status_type         rsp_status;
   logic [TIME_W-1:0]  rsp_time;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_W'(20);
         total_ff <= TIME_W'(60000);
      end else if (csr_we) begin
         if (csr_index == CSR_RATE) begin
            rate_ff <= csr_wdata[RATE_W-1:0];
         end
         if (csr_index == CSR_TOTAL) begin
            total_ff <= csr_wdata;
         end
      end
   end

   assign req_pos = {req_tdata[78:58], req_tdata[57:37], req_tdata[36:16]};
   assign req_att = {req_tdata[126:111], req_tdata[110:95], req_tdata[94:79]};

   swi_front #(
      .MAX_STEPS (MAX_STEPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_first  (req_tuser),
      .req_final  (req_tlast),
      .req_time   (req_tdata[15:0]),
      .req_pos    (req_pos),
      .req_att    (req_att),
      .rate       (rate_ff),
      .total      (total_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   swi_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_cmd   (push_cmd),
      .rd_valid (q_valid),
      .rd_ready (q_pop),
      .rd_cmd   (q_cmd)
   );

   swi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_pop    (q_pop),
      .cmd        (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_time   (rsp_time),
      .rsp_pos    (rsp_pos),
      .rsp_att    (rsp_att),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {1'b0, rsp_att[2], rsp_att[1], rsp_att[0],
                       rsp_pos[2], rsp_pos[1], rsp_pos[0], rsp_time};

endmodule
